// File: hdl/itr_pkg.sv
// ----------------------------------------------------------------------------
// itr_pkg
// shared types and character constants for the integer token reader
// ----------------------------------------------------------------------------
`default_nettype none

package itr_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_NUL       = 8'd0;
   localparam logic [7:0] CHAR_LF        = 8'd10;
   localparam logic [7:0] CHAR_SPACE     = 8'd32;
   localparam logic [7:0] CHAR_HASH      = 8'd35;
   localparam logic [7:0] CHAR_DOLLAR    = 8'd36;
   localparam logic [7:0] CHAR_MINUS     = 8'd45;
   localparam logic [7:0] CHAR_BACKSLASH = 8'd92;

   typedef enum logic [1:0] {
      KIND_NUMBER = 2'd0,
      KIND_BAD    = 2'd1,
      KIND_EOL    = 2'd2,
      KIND_EOT    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SIGN   = 3'd1,
      PH_DOLLAR = 3'd2,
      PH_DIGITS = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic        last;
   } result_type;

   // up to two results from one character
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

// File: hdl/itr_front.sv
// ----------------------------------------------------------------------------
// itr_front
// character classifier and token state machine, one character per cycle while accept is high
// ----------------------------------------------------------------------------
`default_nettype none

module itr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        char_code,
   output itr_pkg::push_type      push
);
   import itr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        hex_ff, hex_in;
   logic        comment_ff, comment_in;
   logic        bslash_ff, bslash_in;

   logic        is_blank, is_dec, is_hexd;
   logic [3:0]  hval;
   logic        do_idle, do_bad, do_skip;
   logic [1:0]  n;
   kind_type    k0, k1;
   logic [31:0] v0;

   always_comb begin
      is_blank = (char_code == CHAR_SPACE) || (char_code inside {[8'd9:8'd13]});
      is_dec   = char_code inside {[8'd48:8'd57]};
      is_hexd  = is_dec || (char_code inside {[8'd65:8'd70]})
                 || (char_code inside {[8'd97:8'd102]});
      hval     = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;
   end

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      hex_in     = hex_ff;
      comment_in = comment_ff;
      bslash_in  = bslash_ff;
      do_idle    = 1'b0;
      do_bad     = 1'b0;
      do_skip    = 1'b0;
      n          = 2'd0;
      k0         = KIND_NUMBER;
      k1         = KIND_NUMBER;
      v0         = 32'd0;

      case (phase_ff)
         PH_DIGITS: begin
            if (hex_ff ? is_hexd : is_dec) begin
               if (hex_ff) begin
                  acc_in = {acc_ff[27:0], 4'd0} + {28'd0, hval};
               end else begin
                  acc_in = {acc_ff[28:0], 3'd0} + {acc_ff[30:0], 1'b0} + {28'd0, hval};
               end
            end else begin
               k0       = KIND_NUMBER;
               v0       = neg_ff ? (32'd0 - acc_ff) : acc_ff;
               n        = 2'd1;
               acc_in   = 32'd0;
               neg_in   = 1'b0;
               hex_in   = 1'b0;
               phase_in = PH_IDLE;
               do_idle  = 1'b1;
            end
         end
         PH_SIGN: begin
            if (char_code == CHAR_DOLLAR) begin
               hex_in   = 1'b1;
               phase_in = PH_DOLLAR;
            end else if (is_dec) begin
               acc_in   = {28'd0, hval};
               phase_in = PH_DIGITS;
            end else begin
               do_bad = 1'b1;
            end
         end
         PH_DOLLAR: begin
            if (is_hexd) begin
               acc_in   = {28'd0, hval};
               phase_in = PH_DIGITS;
            end else begin
               do_bad = 1'b1;
            end
         end
         PH_SKIP: begin
            do_skip = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
            do_idle  = 1'b1;
         end
      endcase

      // between words
      if (do_idle) begin
         if (char_code == CHAR_NUL) begin
            if (n == 2'd0) k0 = KIND_EOT; else k1 = KIND_EOT;
            n          = n + 2'd1;
            phase_in   = PH_IDLE;
            acc_in     = 32'd0;
            neg_in     = 1'b0;
            hex_in     = 1'b0;
            comment_in = 1'b0;
            bslash_in  = 1'b0;
         end else if (bslash_ff) begin
            bslash_in = 1'b0;
            if (char_code != CHAR_LF) begin
               if (n == 2'd0) k0 = KIND_BAD; else k1 = KIND_BAD;
               n          = n + 2'd1;
               acc_in     = 32'd0;
               neg_in     = 1'b0;
               hex_in     = 1'b0;
               comment_in = 1'b0;
               phase_in   = PH_SKIP;
            end
         end else if (char_code == CHAR_LF) begin
            if (n == 2'd0) k0 = KIND_EOL; else k1 = KIND_EOL;
            n          = n + 2'd1;
            comment_in = 1'b0;
         end else if (char_code == CHAR_BACKSLASH) begin
            bslash_in = 1'b1;
         end else if (!(comment_ff || is_blank)) begin
            if (char_code == CHAR_HASH) begin
               comment_in = 1'b1;
            end else if (char_code == CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGN;
            end else if (char_code == CHAR_DOLLAR) begin
               hex_in   = 1'b1;
               phase_in = PH_DOLLAR;
            end else if (is_dec) begin
               acc_in   = {28'd0, hval};
               phase_in = PH_DIGITS;
            end else begin
               if (n == 2'd0) k0 = KIND_BAD; else k1 = KIND_BAD;
               n          = n + 2'd1;
               acc_in     = 32'd0;
               neg_in     = 1'b0;
               hex_in     = 1'b0;
               comment_in = 1'b0;
               phase_in   = PH_SKIP;
            end
         end
      end

      // lone sign or dollar: report, then treat this character as skipped
      if (do_bad) begin
         k0         = KIND_BAD;
         n          = 2'd1;
         acc_in     = 32'd0;
         neg_in     = 1'b0;
         hex_in     = 1'b0;
         comment_in = 1'b0;
         phase_in   = PH_SKIP;
         do_skip    = 1'b1;
      end

      // inside a bad word
      if (do_skip) begin
         if (char_code == CHAR_NUL) begin
            if (n == 2'd0) k0 = KIND_EOT; else k1 = KIND_EOT;
            n          = n + 2'd1;
            phase_in   = PH_IDLE;
            acc_in     = 32'd0;
            neg_in     = 1'b0;
            hex_in     = 1'b0;
            comment_in = 1'b0;
            bslash_in  = 1'b0;
         end else if (bslash_ff) begin
            bslash_in = 1'b0;
         end else if (char_code == CHAR_LF) begin
            if (n == 2'd0) k0 = KIND_EOL; else k1 = KIND_EOL;
            n        = n + 2'd1;
            phase_in = PH_IDLE;
         end else if (is_blank) begin
            phase_in = PH_IDLE;
         end else if (char_code == CHAR_BACKSLASH) begin
            bslash_in = 1'b1;
         end
      end

      push.count        = accept ? n : 2'd0;
      push.first.kind   = k0;
      push.first.value  = v0;
      push.first.last   = (n == 2'd1);
      push.second.kind  = k1;
      push.second.value = 32'd0;
      push.second.last  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         acc_ff     <= 32'd0;
         neg_ff     <= 1'b0;
         hex_ff     <= 1'b0;
         comment_ff <= 1'b0;
         bslash_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         hex_ff     <= hex_in;
         comment_ff <= comment_in;
         bslash_ff  <= bslash_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/itr_queue.sv
// ----------------------------------------------------------------------------
// itr_queue
// result queue, up to two writes and, unless out_stall, one read a cycle, drives the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module itr_queue #(
   parameter int unsigned QUEUE_DEPTH = itr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire itr_pkg::push_type   push,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output itr_pkg::result_type      out_result
);
   import itr_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

   result_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, wr_next, rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   always_comb begin
      out_valid = (count_ff != '0);
      full      = (count_ff > ROOM_LIMIT);
      pop       = out_valid && !out_stall;
      wr_next   = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_ONE;
      out_result = entry_ff[rd_ff];
      case (push.count)
         2'd1:    wr_in = wr_next;
         2'd2:    wr_in = (wr_next == PTR_LAST) ? '0 : wr_next + PTR_ONE;
         default: wr_in = wr_ff;
      endcase
      rd_in    = pop ? ((rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_ONE) : rd_ff;
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/integer_token_reader_unit.sv
// ----------------------------------------------------------------------------
// integer_token_reader_unit
// text stream tokeniser for signed decimal and '$' hex integers
// ----------------------------------------------------------------------------
// Takes one character per transfer on the req_ channel and gives tokens on
// the rsp_ channel: numbers (wrapping modulo 2^32, '-' negates), bad tokens,
// end of line and end of text. Blanks, '#' comments and backslash-newline
// continuations are skipped; after a bad token the rest of that word is
// dropped. One character is taken every cycle while req_stall is low; a
// character gives zero, one or two results, and rsp_last marks the final result
// of a character. The front state machine holds the whole token state and
// settles each character as it is taken; a small result queue between it and
// the result channel lets the input keep flowing while results wait. The
// sustained rate is therefore one character a cycle, limited only by the
// result channel draining one result a cycle: req_stall rises when fewer
// than two queue slots are free. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_token_reader_unit #(
   parameter int unsigned QUEUE_DEPTH = itr_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // character channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_char_code,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic signed [31:0]      rsp_value,
   output logic                    rsp_last
);
   import itr_pkg::*;

   logic       req_accept;
   push_type   push;
   result_type head;
   logic       queue_full;

   // a character transfer completes when the queue has room for two results
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // front: classify the character and advance the token state
   itr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .char_code (req_char_code),
      .push      (push)
   );

   // back: queue results and hand them out one per transfer
   itr_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (head)
   );

   assign rsp_kind  = head.kind;
   assign rsp_value = $signed(head.value);
   assign rsp_last  = head.last;

   // results are only produced by an accepted character
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      !req_accept |-> push.count == 2'd0)
      else $error("results pushed without a character transfer");

   // a single result is the last of its character
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd1 |-> push.first.last)
      else $error("single result not marked last");

   // with two results only the second is last, and the first is not end of text
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.first.last && push.first.kind != KIND_EOT)
      else $error("bad ordering of a result pair");

   // only numbers carry a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_NUMBER) |-> rsp_value == 32'sd0)
      else $error("non-number result with nonzero value");

endmodule

`default_nettype wire
